FILE: rtl/tacr_pkg.sv
package tacr_pkg;

    localparam int unsigned SampleWidth = 12;

    localparam logic [2:0] MODE_START_WRITE = 3'd0;
    localparam logic [2:0] MODE_START_READ  = 3'd1;
    localparam logic [2:0] MODE_WRITE_BYTE  = 3'd2;
    localparam logic [2:0] MODE_READ_BYTE   = 3'd3;
    localparam logic [2:0] MODE_TAKE_COMP   = 3'd4;

    localparam logic [3:0] FN_TEMP0    = 4'h0;
    localparam logic [3:0] FN_AUX      = 4'h2;
    localparam logic [3:0] FN_TEMP1    = 4'h4;
    localparam logic [3:0] FN_DRV_X    = 4'h8;
    localparam logic [3:0] FN_DRV_Y    = 4'h9;
    localparam logic [3:0] FN_DRV_YX   = 4'hA;
    localparam logic [3:0] FN_SETUP    = 4'hB;
    localparam logic [3:0] FN_MEAS_X   = 4'hC;
    localparam logic [3:0] FN_MEAS_Y   = 4'hD;
    localparam logic [3:0] FN_MEAS_Z1  = 4'hE;
    localparam logic [3:0] FN_MEAS_Z2  = 4'hF;

    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_EXTRA_BYTE = 2'd1;
    localparam logic [1:0] ERR_RESERVED   = 2'd2;

    localparam logic CFG_TEMPERATURE = 1'b0;
    localparam logic CFG_AUX         = 1'b1;

    localparam logic [SampleWidth-1:0] TEMP_RESET = 12'h300;
    localparam logic [SampleWidth-1:0] AUX_RESET  = 12'h800;

    localparam logic [1:0] READ_INDEX_MAX = 2'd2;
    localparam logic [1:0] Z2_RELEASE     = 2'd3;

    typedef struct packed {
        logic [2:0]             mode;
        logic [7:0]             data_byte;
        logic [SampleWidth-1:0] touch_x;
        logic [SampleWidth-1:0] touch_y;
        logic [SampleWidth-1:0] touch_z1;
        logic [SampleWidth-1:0] touch_z2;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       completion;
        logic [1:0] error_code;
    } t_out_item;

endpackage

FILE: rtl/touch_adc_command_responder.sv
// Bus-slave command responder for a resistive touchscreen converter.
// Each input transfer carries one bus event (start write, start read, command
// byte, read byte or completion query) together with the live touch codes.
// Each accepted input transfer yields exactly one output transfer holding the
// read byte, the completion flag and an error code.
// An input transfer is registered in the input register, decoded against the
// block state as it leaves that register, and its result is registered in the
// result register, where it is valid on the output until taken. One transfer
// per cycle is sustained while the output is not stalled; the rate is set by
// the single decode stage between the input and result registers.
// When the output is stalled the result register holds its value, the input
// register fills behind it, and then o_in_stall rises until the output moves.
// The two reading registers are written through the configuration channel,
// which is always ready; write them only while no transfer is in flight.
// Synchronous active-low reset empties both registers, clears command state
// except held frame data, and restores default temperature and aux readings.
module touch_adc_command_responder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tacr_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tacr_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [tacr_pkg::SampleWidth-1:0] i_cfg_data
);
    import tacr_pkg::*;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item core_result;
    logic      out_load;
    logic      s1_fire;
    logic      in_take;

    assign out_load    = !r_out_valid || !i_out_stall;
    assign s1_fire     = r_s1_valid && out_load;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_s1_valid && !out_load;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    tacr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s1_fire),
        .i_item      (r_s1_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!r_s1_valid || s1_fire) begin
                r_s1_valid <= in_take;
            end
            if (out_load) begin
                r_out_valid <= s1_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item <= i_in_item;
        end
        if (s1_fire) begin
            r_out_item <= core_result;
        end
    end

endmodule

FILE: rtl/tacr_core.sv
module tacr_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  tacr_pkg::t_in_item          i_item,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [tacr_pkg::SampleWidth-1:0] i_cfg_data,
    output tacr_pkg::t_out_item         o_result
);
    import tacr_pkg::*;

    logic [SampleWidth-1:0] r_temp, n_temp;
    logic [SampleWidth-1:0] r_aux, n_aux;
    logic [7:0]             r_cmd, n_cmd;
    logic [1:0]             r_idx, n_idx;
    logic [3:0]             r_setup, n_setup;
    logic [SampleWidth-1:0] r_result, n_result;
    logic [SampleWidth-1:0] r_frame [4];
    logic [SampleWidth-1:0] n_frame [4];
    logic                   r_held, n_held;
    logic [1:0]             r_z2cnt, n_z2cnt;
    logic                   r_await, n_await;
    logic                   r_pend, n_pend;

    logic [3:0]             cmd_fn;
    logic [3:0]             cur_fn;
    logic                   eight;
    logic [SampleWidth-1:0] sel_x, sel_y, sel_z1, sel_z2;
    logic [1:0]             z2_inc;

    always_comb begin
        cmd_fn = i_item.data_byte[7:4];
        cur_fn = r_cmd[7:4];
        eight  = r_cmd[1];
        sel_x  = r_held ? r_frame[0] : i_item.touch_x;
        sel_y  = r_held ? r_frame[1] : i_item.touch_y;
        sel_z1 = r_held ? r_frame[2] : i_item.touch_z1;
        sel_z2 = r_held ? r_frame[3] : i_item.touch_z2;
        z2_inc = r_z2cnt + 2'd1;

        n_temp   = r_temp;
        n_aux    = r_aux;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_setup  = r_setup;
        n_result = r_result;
        n_frame  = r_frame;
        n_held   = r_held;
        n_z2cnt  = r_z2cnt;
        n_await  = r_await;
        n_pend   = r_pend;
        o_result = '0;

        if (i_cfg_we) begin
            if (i_cfg_index == CFG_TEMPERATURE) begin
                n_temp = i_cfg_data;
            end else begin
                n_aux = i_cfg_data;
            end
        end

        if (i_fire) begin
            case (i_item.mode)
                MODE_START_WRITE: begin
                    n_await = 1'b1;
                    n_pend  = 1'b0;
                end
                MODE_START_READ: begin
                    n_await = 1'b0;
                    n_pend  = 1'b0;
                    n_idx   = '0;
                end
                MODE_WRITE_BYTE: begin
                    if (!r_await) begin
                        o_result.error_code = ERR_EXTRA_BYTE;
                    end else begin
                        n_cmd   = i_item.data_byte;
                        n_idx   = '0;
                        n_pend  = 1'b1;
                        n_await = 1'b0;
                        if (cmd_fn == FN_DRV_YX && !r_held) begin
                            n_frame[0] = i_item.touch_x;
                            n_frame[1] = i_item.touch_y;
                            n_frame[2] = i_item.touch_z1;
                            n_frame[3] = i_item.touch_z2;
                            n_held     = 1'b1;
                            n_z2cnt    = '0;
                        end
                        case (cmd_fn)
                            FN_SETUP: begin
                                if (i_item.data_byte[2]) begin
                                    n_setup  = '0;
                                    n_result = '0;
                                end else begin
                                    n_setup = i_item.data_byte[3:0];
                                end
                            end
                            FN_TEMP0, FN_TEMP1: n_result = r_temp;
                            FN_AUX:             n_result = r_aux;
                            FN_DRV_X, FN_DRV_Y, FN_DRV_YX: n_result = '0;
                            FN_MEAS_X:          n_result = sel_x;
                            FN_MEAS_Y:          n_result = sel_y;
                            FN_MEAS_Z1:         n_result = sel_z1;
                            FN_MEAS_Z2:         n_result = sel_z2;
                            default: begin
                                n_result            = '0;
                                o_result.error_code = ERR_RESERVED;
                            end
                        endcase
                    end
                end
                MODE_READ_BYTE: begin
                    if (r_idx == 2'd0) begin
                        o_result.read_data = r_result[11:4];
                    end else if (!eight) begin
                        o_result.read_data = {r_result[3:0], 4'b0000};
                    end
                    if (r_idx != READ_INDEX_MAX) begin
                        n_idx = r_idx + 2'd1;
                    end
                    if (cur_fn == FN_MEAS_Z2 && r_held &&
                        ((eight && r_idx == 2'd0) || (!eight && r_idx == 2'd1))) begin
                        if (z2_inc == Z2_RELEASE) begin
                            n_held  = 1'b0;
                            n_z2cnt = '0;
                        end else begin
                            n_z2cnt = z2_inc;
                        end
                    end
                end
                MODE_TAKE_COMP: begin
                    o_result.completion = r_pend;
                    n_pend              = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp   <= TEMP_RESET;
            r_aux    <= AUX_RESET;
            r_cmd    <= '0;
            r_idx    <= '0;
            r_setup  <= '0;
            r_result <= '0;
            r_held   <= 1'b0;
            r_z2cnt  <= '0;
            r_await  <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_temp   <= n_temp;
            r_aux    <= n_aux;
            r_cmd    <= n_cmd;
            r_idx    <= n_idx;
            r_setup  <= n_setup;
            r_result <= n_result;
            r_held   <= n_held;
            r_z2cnt  <= n_z2cnt;
            r_await  <= n_await;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

endmodule

FILE: bench/touch_adc_response_checker.sv
module touch_adc_response_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  tacr_pkg::t_in_item               i_in_item,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  tacr_pkg::t_out_item              i_out_item,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [tacr_pkg::SampleWidth-1:0] i_cfg_data,
    input  logic                             i_end_check,
    output int                               o_pending,
    output int                               o_mismatches
);
    import tacr_pkg::*;

    localparam int PrintLimit = 40;

    logic [7:0]             cmd_reg;
    logic [1:0]             read_index;
    logic [3:0]             setup_nibble;
    logic [SampleWidth-1:0] result_code;
    logic [SampleWidth-1:0] held_frame [4];
    logic                   frame_held;
    logic [1:0]             z2_reads;
    logic                   awaiting_cmd;
    logic                   comp_pending;
    logic [SampleWidth-1:0] temp_reading;
    logic [SampleWidth-1:0] aux_reading;

    t_out_item pending_replies [$];
    t_out_item want_reply;
    t_out_item new_reply;
    bit        end_done = 1'b0;

    task automatic flag(input string msg);
        if (o_mismatches < PrintLimit) begin
            $display("%0t: %s", $time, msg);
        end
        o_mismatches++;
    endtask

    // Runs one command byte and reports whether its function is reserved.
    function automatic bit apply_command(input t_in_item ev);
        logic [3:0]             fn;
        logic [SampleWidth-1:0] live [4];
        logic [SampleWidth-1:0] src [4];
        bit                     reserved;
        fn = ev.data_byte[7:4];
        reserved = 1'b0;
        live[0] = ev.touch_x;
        live[1] = ev.touch_y;
        live[2] = ev.touch_z1;
        live[3] = ev.touch_z2;
        cmd_reg = ev.data_byte;
        read_index = '0;
        if (fn == FN_DRV_YX && !frame_held) begin
            held_frame = live;
            frame_held = 1'b1;
            z2_reads = '0;
        end
        if (fn == FN_SETUP) begin
            setup_nibble = ev.data_byte[3:0];
            if (setup_nibble[2]) begin
                setup_nibble = '0;
                result_code = '0;
            end
            return 1'b0;
        end
        for (int k = 0; k < 4; k++) begin
            src[k] = frame_held ? held_frame[k] : live[k];
        end
        case (fn)
            FN_TEMP0, FN_TEMP1: result_code = temp_reading;
            FN_AUX: result_code = aux_reading;
            FN_DRV_X, FN_DRV_Y, FN_DRV_YX: result_code = '0;
            FN_MEAS_X: result_code = src[0];
            FN_MEAS_Y: result_code = src[1];
            FN_MEAS_Z1: result_code = src[2];
            FN_MEAS_Z2: result_code = src[3];
            default: begin
                result_code = '0;
                reserved = 1'b1;
            end
        endcase
        return reserved;
    endfunction

    function automatic logic [7:0] next_read_byte();
        logic       eight;
        logic [1:0] idx;
        logic [7:0] value;
        eight = cmd_reg[1];
        idx = read_index;
        if (idx == 2'd0) begin
            value = result_code[11:4];
        end else begin
            value = eight ? 8'h00 : {result_code[3:0], 4'h0};
        end
        if (read_index < READ_INDEX_MAX) begin
            read_index++;
        end
        // The Z2 read that completes a sample counts toward releasing the frame.
        if (cmd_reg[7:4] == FN_MEAS_Z2 && frame_held
                && ((eight && idx == 2'd0) || (!eight && idx == 2'd1))) begin
            z2_reads++;
            if (z2_reads >= Z2_RELEASE) begin
                frame_held = 1'b0;
                z2_reads = '0;
            end
        end
        return value;
    endfunction

    function automatic t_out_item compute_reply(input t_in_item ev);
        t_out_item rep;
        rep = '0;
        case (ev.mode)
            MODE_START_WRITE: begin
                awaiting_cmd = 1'b1;
                comp_pending = 1'b0;
            end
            MODE_START_READ: begin
                awaiting_cmd = 1'b0;
                comp_pending = 1'b0;
                read_index = '0;
            end
            MODE_WRITE_BYTE: begin
                if (!awaiting_cmd) begin
                    rep.error_code = ERR_EXTRA_BYTE;
                end else begin
                    if (apply_command(ev)) begin
                        rep.error_code = ERR_RESERVED;
                    end
                    comp_pending = 1'b1;
                    awaiting_cmd = 1'b0;
                end
            end
            MODE_READ_BYTE: rep.read_data = next_read_byte();
            MODE_TAKE_COMP: begin
                rep.completion = comp_pending;
                comp_pending = 1'b0;
            end
            default: ;
        endcase
        return rep;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_reg = '0;
            read_index = '0;
            setup_nibble = '0;
            result_code = '0;
            held_frame = '{default: '0};
            frame_held = 1'b0;
            z2_reads = '0;
            awaiting_cmd = 1'b0;
            comp_pending = 1'b0;
            temp_reading = TEMP_RESET;
            aux_reading = AUX_RESET;
            pending_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TEMPERATURE) begin
                    temp_reading = i_cfg_data;
                end else begin
                    aux_reading = i_cfg_data;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    flag("Result transfer arrived with no expectation pending.");
                end else begin
                    want_reply = pending_replies.pop_front();
                    if (i_out_item.read_data !== want_reply.read_data) begin
                        flag($sformatf("read_data is %0h, expected %0h.",
                            i_out_item.read_data, want_reply.read_data));
                    end
                    if (i_out_item.completion !== want_reply.completion) begin
                        flag($sformatf("completion is %0b, expected %0b.",
                            i_out_item.completion, want_reply.completion));
                    end
                    if (i_out_item.error_code !== want_reply.error_code) begin
                        flag($sformatf("error_code is %0d, expected %0d.",
                            i_out_item.error_code, want_reply.error_code));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                new_reply = compute_reply(i_in_item);
                pending_replies.push_back(new_reply);
            end
            if (i_end_check && !end_done) begin
                end_done = 1'b1;
                if (pending_replies.size() != 0) begin
                    flag($sformatf("%0d expected results never arrived.",
                        pending_replies.size()));
                end
            end
        end
        o_pending = pending_replies.size();
    end

endmodule

FILE: bench/tb_touch_adc_command_responder.sv
module tb_touch_adc_command_responder;
    import tacr_pkg::*;

    localparam int HoldCycles    = 300;
    localparam int WatchdogLimit = 3000;
    localparam int PhaseEvents   = 340;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   o_in_stall;
    t_in_item               in_item = '0;
    logic                   o_out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              o_out_item;
    logic                   cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   cfg_index = CFG_TEMPERATURE;
    logic [SampleWidth-1:0] cfg_data = '0;
    logic                   end_check = 1'b0;
    int                     pending;
    int                     mismatches;

    logic tx_gaps = 1'b1;
    logic rx_gaps = 1'b1;
    logic hold_req = 1'b0;
    int   events_sent = 0;
    int   idle_cycles = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    touch_adc_command_responder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    touch_adc_response_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (o_out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_end_check  (end_check),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver stalls at random, or holds off for a long stretch on request.
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                for (int n = 0; n < HoldCycles; n++) begin
                    @(negedge clk);
                end
            end
            out_stall <= rx_gaps && ($urandom_range(99) < 13);
        end
    end

    function automatic logic [SampleWidth-1:0] rand_code();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return SampleWidth'($urandom_range(4095));
        endcase
    endfunction

    function automatic t_in_item make_event(input logic [2:0] mode, input logic [7:0] value);
        t_in_item ev;
        ev.mode = mode;
        ev.data_byte = value;
        ev.touch_x = rand_code();
        ev.touch_y = rand_code();
        ev.touch_z1 = rand_code();
        ev.touch_z2 = rand_code();
        return ev;
    endfunction

    // Starts at a falling edge and returns at the falling edge after the transfer.
    task automatic offer(input t_in_item ev);
        if (tx_gaps && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= ev;
        do @(posedge clk); while (o_in_stall);
        @(negedge clk);
        events_sent++;
    endtask

    task automatic send_event(input logic [2:0] mode, input logic [7:0] value);
        offer(make_event(mode, value));
    endtask

    task automatic send_touch(input logic [7:0] value, input logic [11:0] x,
                              input logic [11:0] y, input logic [11:0] z1,
                              input logic [11:0] z2);
        t_in_item ev;
        ev = '{mode: MODE_WRITE_BYTE, data_byte: value, touch_x: x, touch_y: y,
               touch_z1: z1, touch_z2: z2};
        offer(ev);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_readings(input logic [11:0] temp, input logic [11:0] aux);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TEMPERATURE;
        cfg_data <= temp;
        do @(posedge clk); while (!o_cfg_ready);
        @(negedge clk);
        cfg_index <= CFG_AUX;
        cfg_data <= aux;
        do @(posedge clk); while (!o_cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_command();
        logic [3:0] fn;
        case ($urandom_range(9))
            0, 1, 2: fn = FN_MEAS_Z2;
            3, 4: fn = FN_DRV_YX;
            5: fn = FN_SETUP;
            default: fn = 4'($urandom_range(15));
        endcase
        return {fn, 4'($urandom_range(15))};
    endfunction

    // Mostly complete write-then-read sequences; the rest is loose bus noise.
    task automatic random_transaction();
        logic [2:0] mode;
        if ($urandom_range(99) < 15) begin
            mode = ($urandom_range(49) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(4));
            send_event(mode, 8'($urandom));
        end else begin
            send_event(MODE_START_WRITE, 8'($urandom));
            send_event(MODE_WRITE_BYTE, random_command());
            if ($urandom_range(3) == 0) begin
                send_event(MODE_TAKE_COMP, 8'($urandom));
            end
            if ($urandom_range(9) == 0) begin
                send_event(MODE_WRITE_BYTE, 8'($urandom));
            end
            send_event(MODE_START_READ, 8'($urandom));
            repeat ($urandom_range(1, 3)) send_event(MODE_READ_BYTE, 8'($urandom));
            if ($urandom_range(2) == 0) begin
                send_event(MODE_TAKE_COMP, 8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        int phase_end;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_event(MODE_TAKE_COMP, 8'h00);
        send_event(MODE_READ_BYTE, 8'h00);
        send_event(MODE_WRITE_BYTE, 8'hFF);
        send_event(MODE_START_WRITE, 8'h00);
        send_touch({FN_MEAS_X, 4'h0}, '1, '0, '0, '0);
        send_event(MODE_TAKE_COMP, 8'h00);
        send_event(MODE_START_READ, 8'h00);
        repeat (3) send_event(MODE_READ_BYTE, 8'h00);
        send_event(MODE_START_WRITE, 8'h00);
        send_event(MODE_WRITE_BYTE, 8'h12);
        send_event(MODE_START_WRITE, 8'h00);
        send_touch({FN_DRV_YX, 4'h0}, '0, '1, 12'hA5A, 12'h5A5);
        send_event(MODE_START_WRITE, 8'h00);
        send_touch({FN_MEAS_Z2, 4'h2}, '1, '1, '1, '1);
        send_event(MODE_READ_BYTE, 8'h00);
        send_event(MODE_WRITE_BYTE, 8'h00);
        send_event(MODE_START_WRITE, 8'h00);
        send_event(MODE_WRITE_BYTE, {FN_SETUP, 4'h4});
        send_event(MODE_READ_BYTE, 8'h00);
        send_event(MODE_START_WRITE, 8'h00);
        send_event(MODE_WRITE_BYTE, {FN_TEMP1, 4'h2});
        repeat (2) send_event(MODE_READ_BYTE, 8'h00);
        send_event(3'd5, 8'hFF);
        send_event(3'd7, 8'hFF);

        for (int p = 0; p < 5; p++) begin
            wait_drained();
            case (p)
                0: load_readings('0, '1);
                1: load_readings('1, '0);
                2: load_readings(12'($urandom_range(4095)), 12'($urandom_range(4095)));
                3: load_readings('1, '1);
                default: load_readings('0, '0);
            endcase
            tx_gaps = (p != 2);
            rx_gaps = (p != 2);
            if (p == 0) begin
                hold_req = 1'b1;
            end
            phase_end = events_sent + PhaseEvents;
            while (events_sent < phase_end) random_transaction();
        end

        wait_drained();
        repeat (8) @(negedge clk);
        end_check <= 1'b1;
        repeat (2) @(negedge clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
